/* rtl/core/bfu_pkg.sv */
package bfu_pkg;

	localparam int FUNC_W   = 3;
	localparam int WORD_W   = 32;
	localparam int WCODE_W  = 5;
	localparam int POS_W    = 5;
	localparam int CNT_W    = 6;

	// slave tdata: operand_word, insert_source, bit_offset, width_code, pad
	localparam int S_FIELDS_W = 3 * WORD_W + WCODE_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

	// master tdata: new_operand_word, data_result, flag_negative, flag_zero, pad
	localparam int M_FIELDS_W = 2 * WORD_W + 2;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [WORD_W-1:0] FULL_MASK = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_TEST    = 3'd0,
		FN_CHANGE  = 3'd1,
		FN_SET     = 3'd2,
		FN_CLEAR   = 3'd3,
		FN_EXTU    = 3'd4,
		FN_EXTS    = 3'd5,
		FN_FFO     = 3'd6,
		FN_INSERT  = 3'd7
	} func_t;

	// leading zero count of a nonzero word, binary search in five steps
	function automatic logic [POS_W-1:0] bfu_clz(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] v;
		logic [POS_W-1:0]  n;
		v = x;
		n = '0;
		if (v[31:16] == 16'd0) begin
			n = n + 5'd16;
			v = v << 16;
		end
		if (v[31:24] == 8'd0) begin
			n = n + 5'd8;
			v = v << 8;
		end
		if (v[31:28] == 4'd0) begin
			n = n + 5'd4;
			v = v << 4;
		end
		if (v[31:30] == 2'd0) begin
			n = n + 5'd2;
			v = v << 2;
		end
		if (v[31] == 1'b0) begin
			n = n + 5'd1;
		end
		return n;
	endfunction

endpackage

/* rtl/core/bitfield_operation_unit.sv */
// Bitfield operation unit: register forms of the test/change/set/clear,
// extract (unsigned, signed), find-first-one and insert bitfield operations.
//
// Input channel (s_*): one word per operation. s_tuser carries the function
// code; s_tdata carries the operand word, the insert source, the signed bit
// offset (counted from the MSB, wrapping modulo 32) and the width code
// (0 means a 32-bit field).
// Output channel (m_*): one word per input word, in order: the updated
// operand word, the data result and the N and Z flags.
//
// A word passes through an input register and then a result register, with
// the rotate/mask/count logic between them.
// Throughput is one word per cycle while m_tready is high; the input register
// advances whenever the result register is empty or being drained, so
// s_tready stays high while m_tready is high.
// When the receiver stalls, the result word holds on m_tdata, one more word
// may wait in the input register, and s_tready then drops.
// Reset (arst_n low) empties both registers at once; no words are in flight.
module bitfield_operation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] operand_word, [63:32] insert_source, [95:64] bit_offset,
	// [100:96] width_code, [103:101] zero
	input  logic [bfu_pkg::S_DATA_W-1:0]  s_tdata,
	// [2:0] func
	input  logic [bfu_pkg::FUNC_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] new_operand_word, [63:32] data_result, [64] flag_negative,
	// [65] flag_zero, [71:66] zero
	output logic [bfu_pkg::M_DATA_W-1:0]  m_tdata
);
	import bfu_pkg::*;

	// input register
	logic               valid_s1;
	func_t              func_s1;
	logic [WORD_W-1:0]  word_s1;
	logic [WORD_W-1:0]  src_s1;
	logic [WORD_W-1:0]  offs_s1;
	logic [WCODE_W-1:0] wcode_s1;

	// result register
	logic               valid_s2;
	logic [WORD_W-1:0]  new_word_s2;
	logic [WORD_W-1:0]  data_s2;
	logic               neg_s2;
	logic               zero_s2;

	logic adv_s1;
	logic adv_s2;

	// datapath between the registers
	logic [CNT_W-1:0]      width;
	logic [POS_W-1:0]      pos;
	logic [POS_W-1:0]      sh;
	logic [WORD_W-1:0]     hmask;
	logic [2*WORD_W-1:0]   word_rol2;
	logic [2*WORD_W-1:0]   mask_ror2;
	logic [2*WORD_W-1:0]   ins_ror2;
	logic [WORD_W-1:0]     aligned;
	logic [WORD_W-1:0]     place_mask;
	logic [WORD_W-1:0]     ins_aligned;
	logic [WORD_W-1:0]     placed;
	logic [WORD_W-1:0]     field_u;
	logic [WORD_W-1:0]     field_s;
	logic [POS_W-1:0]      lead;
	logic [CNT_W-1:0]      cnt;
	logic [WORD_W-1:0]     flag_word;
	logic [WORD_W-1:0]     new_word;
	logic [WORD_W-1:0]     data;

	// advance the result register when empty or drained, the input register
	// when it is empty or its word moves on
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			func_s1  <= func_t'(s_tuser);
			word_s1  <= s_tdata[WORD_W-1:0];
			src_s1   <= s_tdata[2*WORD_W-1:WORD_W];
			offs_s1  <= s_tdata[3*WORD_W-1:2*WORD_W];
			wcode_s1 <= s_tdata[3*WORD_W+WCODE_W-1:3*WORD_W];
		end
	end

	always_comb begin
		width = (wcode_s1 == '0) ? CNT_W'(WORD_W) : {1'b0, wcode_s1};
		pos   = offs_s1[POS_W-1:0];
		// 32 - width, modulo 32
		sh    = POS_W'(0) - wcode_s1;
		hmask = FULL_MASK << sh;

		// rotate the word left by pos so the field starts at bit 31
		word_rol2 = {word_s1, word_s1} << pos;
		aligned   = word_rol2[2*WORD_W-1:WORD_W] & hmask;

		// rotate masks and inserted bits back right into place
		mask_ror2   = {hmask, hmask} >> pos;
		place_mask  = mask_ror2[WORD_W-1:0];
		ins_aligned = src_s1 << sh;
		ins_ror2    = {ins_aligned, ins_aligned} >> pos;
		placed      = ins_ror2[WORD_W-1:0];

		field_u = aligned >> sh;
		field_s = WORD_W'($signed(aligned) >>> sh);

		// an empty field counts its full width
		lead = bfu_clz(aligned);
		cnt  = (aligned == '0) ? width : {1'b0, lead};

		new_word  = word_s1;
		data      = '0;
		flag_word = aligned;
		unique case (func_s1)
			FN_TEST: begin
			end
			FN_CHANGE: begin
				new_word = word_s1 ^ place_mask;
			end
			FN_SET: begin
				new_word = word_s1 | place_mask;
			end
			FN_CLEAR: begin
				new_word = word_s1 & ~place_mask;
			end
			FN_EXTU: begin
				data = field_u;
			end
			FN_EXTS: begin
				data = field_s;
			end
			FN_FFO: begin
				data = offs_s1 + {{(WORD_W-CNT_W){1'b0}}, cnt};
			end
			FN_INSERT: begin
				new_word  = (word_s1 & ~place_mask) | placed;
				flag_word = ins_aligned;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			new_word_s2 <= new_word;
			data_s2     <= data;
			neg_s2      <= flag_word[WORD_W-1];
			zero_s2     <= (flag_word == '0);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_DATA_W-M_FIELDS_W){1'b0}}, zero_s2, neg_s2, data_s2, new_word_s2};

endmodule

/* rtl/core/bfu_checker.sv */
module bfu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bfu_pkg::M_DATA_W-1:0]  m_tdata
);
	import bfu_pkg::*;

	localparam int NEG_BIT  = 2 * WORD_W;
	localparam int ZERO_BIT = 2 * WORD_W + 1;

	// nothing in flight once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a draining receiver never blocks the input side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// an accepted word moves from the input register into the result register when the output drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("result missing two cycles after acceptance");

	// N is a bit of the same field that Z tests, so both cannot be set
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[NEG_BIT] && m_tdata[ZERO_BIT]))
		else $error("N and Z both set");

endmodule

bind bitfield_operation_unit bfu_checker u_bfu_checker (.*);
